/* rtl/flft_pkg.sv */
// Shared types, constants and helpers for the task queue with lowest free tag allocator
`timescale 1ns / 1ps
`default_nettype none
package flft_pkg;

  localparam int TAG_POOL  = 32;
  localparam int DATE_BITS = 32;
  localparam int TAG_W     = (TAG_POOL > 1) ? $clog2(TAG_POOL) : 1;
  localparam int CNT_W     = $clog2(TAG_POOL + 1);

  typedef logic [TAG_W-1:0]     tag_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [DATE_BITS-1:0] date_t;
  typedef logic [TAG_POOL-1:0]  tag_map_t;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NO_TAG    = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RES_FAIL,
    RES_ADD,
    RES_READ
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RING,
    S_STORE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     add_commit;
    logic     pop_commit;
    logic     rd_store;
    logic     sel_ring;
    logic     load_res;
    res_sel_t res_sel;
    status_t  fail_status;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic found;
  } dp_stat_t;

  typedef struct packed {
    logic found;
    tag_t tag;
  } free_tag_t;

  function automatic free_tag_t lowest_free(input tag_map_t in_use);
    free_tag_t res;
    res.found = 1'b0;
    res.tag   = '0;
    for (int i = TAG_POOL - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        res.found = 1'b1;
        res.tag   = TAG_W'(i);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/flft_dp.sv */
// Datapath: request capture, order ring, payload stores, tag map and result registers
`timescale 1ns / 1ps
`default_nettype none
module flft_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire flft_pkg::dp_cmd_t cmd,
  output flft_pkg::dp_stat_t     stat,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [7:0]        in_command_number,
  input  wire logic [31:0]       in_timestamp,
  input  wire logic [4:0]        in_query_tag,
  output logic [1:0]             out_status,
  output logic [4:0]             out_task_tag,
  output logic [7:0]             out_command_out,
  output logic [31:0]            out_timestamp_out,
  output logic [5:0]             out_occupancy
);
  import flft_pkg::*;

  req_t       req_r;
  logic [7:0] cmd_r;
  date_t      date_r;
  logic [4:0] qtag_r;

  tag_t       ring_mem [TAG_POOL];
  logic [7:0] cmd_mem  [TAG_POOL];
  date_t      date_mem [TAG_POOL];

  tag_t       head_r, head_nxt;
  tag_t       tail_r, tail_nxt;
  cnt_t       count_r, count_nxt;
  tag_map_t   in_use_r, in_use_nxt;

  tag_t       ring_q_r;
  tag_t       rd_tag_r, rd_tag_nxt;
  logic [7:0] cmd_q_r;
  date_t      date_q_r;

  status_t    res_status_r;
  tag_t       res_tag_r;
  logic [7:0] res_cmd_r;
  date_t      res_date_r;

  free_tag_t  free;
  logic       qtag_valid;

  assign free       = lowest_free(in_use_r);
  assign qtag_valid = (32'(qtag_r) < 32'(TAG_POOL));
  assign rd_tag_nxt = cmd.sel_ring ? ring_q_r : TAG_W'(qtag_r);

  assign stat.req   = req_r;
  assign stat.full  = !free.found || (32'(count_r) >= 32'(TAG_POOL));
  assign stat.empty = (count_r == '0);
  assign stat.found = qtag_valid && in_use_r[TAG_W'(qtag_r)];

  // capture request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_t'(in_req_type);
      cmd_r  <= in_command_number;
      date_r <= DATE_BITS'(in_timestamp);
      qtag_r <= in_query_tag;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      ring_mem[tail_r]   <= free.tag;
      cmd_mem[free.tag]  <= cmd_r;
      date_mem[free.tag] <= date_r;
    end
    ring_q_r <= ring_mem[head_r];
    if (cmd.rd_store) begin
      rd_tag_r <= rd_tag_nxt;
      cmd_q_r  <= cmd_mem[rd_tag_nxt];
      date_q_r <= date_mem[rd_tag_nxt];
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    in_use_nxt = in_use_r;
    if (cmd.add_commit) begin
      in_use_nxt[free.tag] = 1'b1;
      tail_nxt  = (32'(tail_r) == TAG_POOL - 1) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop_commit) begin
      in_use_nxt[rd_tag_r] = 1'b0;
      head_nxt  = (32'(head_r) == TAG_POOL - 1) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      in_use_r <= '0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      case (cmd.res_sel)
        RES_ADD: begin
          res_status_r <= ST_OK;
          res_tag_r    <= free.tag;
          res_cmd_r    <= cmd_r;
          res_date_r   <= date_r;
        end
        RES_READ: begin
          res_status_r <= ST_OK;
          res_tag_r    <= rd_tag_r;
          res_cmd_r    <= cmd_q_r;
          res_date_r   <= date_q_r;
        end
        default: begin
          res_status_r <= cmd.fail_status;
          res_tag_r    <= '0;
          res_cmd_r    <= '0;
          res_date_r   <= '0;
        end
      endcase
    end
  end

  assign out_status        = res_status_r;
  assign out_task_tag      = 5'(res_tag_r);
  assign out_command_out   = res_cmd_r;
  assign out_timestamp_out = 32'(res_date_r);
  assign out_occupancy     = 6'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TAG_POOL)
    else $error("queued count above pool size");

  a_map_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'($countones(in_use_r)) == 32'(count_r))
    else $error("tag map out of step with queued count");

  a_pop_clears_tag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_commit |=> !in_use_r[$past(rd_tag_r)])
    else $error("removed tag still marked in use");

endmodule
`default_nettype wire

/* rtl/flft_ctrl.sv */
// Controller state machine sequencing each request through the datapath
`timescale 1ns / 1ps
`default_nettype none
module flft_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic                    out_valid,
  input  wire flft_pkg::dp_stat_t stat,
  output flft_pkg::dp_cmd_t       cmd
);
  import flft_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = !((state_r == S_IDLE) || (state_r == S_RESP));
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (stat.req)
          REQ_ADD:    state_nxt = S_RESP;
          REQ_LOOKUP: state_nxt = stat.found ? S_STORE : S_RESP;
          default:    state_nxt = stat.empty ? S_RESP : S_RING;
        endcase
      end
      S_RING:  state_nxt = S_STORE;
      S_STORE: state_nxt = S_RESP;
      S_RESP:  state_nxt = accept ? S_EXEC : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.res_sel     = RES_FAIL;
    cmd.fail_status = ST_OK;
    cmd.capture     = accept;
    unique case (state_r)
      S_EXEC: begin
        unique case (stat.req)
          REQ_ADD: begin
            cmd.load_res = 1'b1;
            if (stat.full) begin
              cmd.fail_status = ST_NO_TAG;
            end else begin
              cmd.add_commit = 1'b1;
              cmd.res_sel    = RES_ADD;
            end
          end
          REQ_LOOKUP: begin
            if (stat.found) begin
              cmd.rd_store = 1'b1;
            end else begin
              cmd.load_res    = 1'b1;
              cmd.fail_status = ST_NOT_FOUND;
            end
          end
          default: begin
            if (stat.empty) begin
              cmd.load_res    = 1'b1;
              cmd.fail_status = ST_EMPTY;
            end
          end
        endcase
      end
      S_RING: begin
        cmd.rd_store = 1'b1;
        cmd.sel_ring = 1'b1;
      end
      S_STORE: begin
        cmd.load_res   = 1'b1;
        cmd.res_sel    = RES_READ;
        cmd.pop_commit = (stat.req == REQ_DELETE);
      end
      default: ;
    endcase
  end

  assign out_valid = (state_r == S_RESP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted transfer did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_load_before_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.load_res))
    else $error("result shown without a result load");

endmodule
`default_nettype wire

/* rtl/fifo_with_lowest_free_tag.sv */
// Top level of the task queue with lowest free tag allocator
// Usage:
//   Input: drive in_req_type, in_command_number, in_timestamp and in_query_tag and
//   raise start; the transfer is taken at the edge where start is high and busy low.
//   Output: each request gives one result, held on the out_ ports for one cycle
//   with out_valid high; the receiver cannot stall and must take it then.
//   After the accepting edge each request passes the execute state; add and any failed
//   request then give the strobe, a lookup that hits first reads the stores, and peek or
//   delete read the order ring and then the stores. A new request may be accepted in
//   the strobe cycle; the single read port of the order ring and of the payload stores
//   sets the longer paths (ring read, then store read).
//   Tags are the lowest free index of a 32-entry pool; out_occupancy is the queued
//   count after the request.
//   Reset (rst_n low, synchronous) empties the queue and frees all tags; the
//   payload stores keep no reset value and are only read where an add wrote them.
`timescale 1ns / 1ps
`default_nettype none
module fifo_with_lowest_free_tag (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_command_number,
  input  wire logic [31:0] in_timestamp,
  input  wire logic [4:0]  in_query_tag,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [4:0]       out_task_tag,
  output logic [7:0]       out_command_out,
  output logic [31:0]      out_timestamp_out,
  output logic [5:0]       out_occupancy
);
  import flft_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  flft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  flft_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req_type),
    .in_command_number (in_command_number),
    .in_timestamp      (in_timestamp),
    .in_query_tag      (in_query_tag),
    .out_status        (out_status),
    .out_task_tag      (out_task_tag),
    .out_command_out   (out_command_out),
    .out_timestamp_out (out_timestamp_out),
    .out_occupancy     (out_occupancy)
  );

endmodule
`default_nettype wire

/* tb/sv/queue_checker.sv */
// Checker for the task queue: watches both channels, predicts each result and compares
`timescale 1ns / 1ps
`default_nettype none
module queue_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_command_number,
  input  wire logic [31:0] in_timestamp,
  input  wire logic [4:0]  in_query_tag,
  input  wire logic        out_valid,
  input  wire logic [1:0]  out_status,
  input  wire logic [4:0]  out_task_tag,
  input  wire logic [7:0]  out_command_out,
  input  wire logic [31:0] out_timestamp_out,
  input  wire logic [5:0]  out_occupancy,
  output int               mismatches,
  output int               outstanding
);
  import flft_pkg::*;

  typedef struct packed {
    status_t    status;
    tag_t       tag;
    logic [7:0] cmd;
    date_t      stamp;
    logic [5:0] occ;
  } task_report_t;

  tag_t         ring_tags [TAG_POOL];
  tag_t         head_idx;
  tag_t         tail_idx;
  logic [5:0]   queued;
  tag_map_t     tags_taken;
  logic [7:0]   cmd_by_tag [TAG_POOL];
  date_t        stamp_by_tag [TAG_POOL];
  task_report_t awaited_reports [$];

  function automatic task_report_t serve_request(input req_t req, input logic [7:0] cmd,
                                                 input date_t stamp, input tag_t qtag);
    task_report_t rep;
    int           free_tag;
    tag_t         t;
    rep        = '0;
    rep.status = ST_OK;
    free_tag   = -1;
    case (req) inside
      REQ_ADD: begin
        for (int i = 0; i < TAG_POOL; i++) begin
          if (free_tag < 0 && !tags_taken[i]) free_tag = i;
        end
        if (free_tag < 0 || queued >= TAG_POOL) begin
          rep.status = ST_NO_TAG;
        end else begin
          t               = tag_t'(free_tag);
          tags_taken[t]   = 1'b1;
          cmd_by_tag[t]   = cmd;
          stamp_by_tag[t] = stamp;
          ring_tags[tail_idx] = t;
          tail_idx        = tail_idx + 1'b1;
          queued          = queued + 1'b1;
          rep.tag         = t;
          rep.cmd         = cmd;
          rep.stamp       = stamp;
        end
      end
      REQ_DELETE, REQ_PEEK: begin
        if (queued == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          t = ring_tags[head_idx];
          if (req == REQ_DELETE) begin
            tags_taken[t] = 1'b0;
            head_idx      = head_idx + 1'b1;
            queued        = queued - 1'b1;
          end
          rep.tag   = t;
          rep.cmd   = cmd_by_tag[t];
          rep.stamp = stamp_by_tag[t];
        end
      end
      default: begin
        if (tags_taken[qtag]) begin
          rep.tag   = qtag;
          rep.cmd   = cmd_by_tag[qtag];
          rep.stamp = stamp_by_tag[qtag];
        end else begin
          rep.status = ST_NOT_FOUND;
        end
      end
    endcase
    rep.occ = queued;
    return rep;
  endfunction

  always @(posedge clk) begin
    task_report_t seen;
    task_report_t want;
    if (!rst_n) begin
      head_idx    = '0;
      tail_idx    = '0;
      queued      = '0;
      tags_taken  = '0;
      mismatches  = 0;
      awaited_reports.delete();
    end else begin
      if (out_valid) begin
        seen.status = status_t'(out_status);
        seen.tag    = out_task_tag;
        seen.cmd    = out_command_out;
        seen.stamp  = out_timestamp_out;
        seen.occ    = out_occupancy;
        if (awaited_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result status %0d tag %0d cmd %0h stamp %0h occ %0d",
                   $time, seen.status, seen.tag, seen.cmd, seen.stamp, seen.occ);
        end else begin
          want = awaited_reports.pop_front();
          if (seen.status != want.status || seen.tag != want.tag || seen.cmd != want.cmd ||
              seen.stamp != want.stamp || seen.occ != want.occ) begin
            mismatches++;
            $display("%0t: expected status %0d tag %0d cmd %0h stamp %0h occ %0d",
                     $time, want.status, want.tag, want.cmd, want.stamp, want.occ);
            $display("%0t:      got status %0d tag %0d cmd %0h stamp %0h occ %0d",
                     $time, seen.status, seen.tag, seen.cmd, seen.stamp, seen.occ);
          end
        end
      end
      if (start && !busy) begin
        awaited_reports.push_back(serve_request(req_t'(in_req_type), in_command_number,
                                                in_timestamp, in_query_tag));
      end
    end
    outstanding = awaited_reports.size();
  end

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Top of the task queue testbench: clock, reset, request stimulus with idling, verdict
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import flft_pkg::*;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } req_mix_t;

  localparam int RANDOM_REQUESTS = 400;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [7:0]  in_command_number;
  logic [31:0] in_timestamp;
  logic [4:0]  in_query_tag;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [4:0]  out_task_tag;
  logic [7:0]  out_command_out;
  logic [31:0] out_timestamp_out;
  logic [5:0]  out_occupancy;
  int          mismatches;
  int          outstanding;

  fifo_with_lowest_free_tag u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_command_number (in_command_number),
    .in_timestamp      (in_timestamp),
    .in_query_tag      (in_query_tag),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_task_tag      (out_task_tag),
    .out_command_out   (out_command_out),
    .out_timestamp_out (out_timestamp_out),
    .out_occupancy     (out_occupancy)
  );

  queue_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_command_number (in_command_number),
    .in_timestamp      (in_timestamp),
    .in_query_tag      (in_query_tag),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_task_tag      (out_task_tag),
    .out_command_out   (out_command_out),
    .out_timestamp_out (out_timestamp_out),
    .out_occupancy     (out_occupancy),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_request(input req_t req, input logic [7:0] cmd,
                              input logic [31:0] stamp, input logic [4:0] qtag);
    in_req_type       = req;
    in_command_number = cmd;
    in_timestamp      = stamp;
    in_query_tag      = qtag;
    start             = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
  endtask

  task automatic pause(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic req_t pick_request(input req_mix_t mix);
    int   roll;
    int   add_share;
    int   delete_share;
    req_t req;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin add_share = 80; delete_share = 8;  end
      MIX_DRAIN: begin add_share = 15; delete_share = 60; end
      default:   begin add_share = 35; delete_share = 30; end
    endcase
    if (roll < add_share) req = REQ_ADD;
    else if (roll < add_share + delete_share) req = REQ_DELETE;
    else if (roll < add_share + delete_share + 8) req = REQ_PEEK;
    else req = REQ_LOOKUP;
    return req;
  endfunction

  initial begin
    int       sent;
    int       burst;
    int       seg_left;
    req_mix_t mix;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_req_type       = REQ_ADD;
    in_command_number = '0;
    in_timestamp      = '0;
    in_query_tag      = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_request(REQ_DELETE, 8'hff, 32'hffff_ffff, 5'd31);
    send_request(REQ_PEEK,   8'h00, 32'h0,         5'd0);
    send_request(REQ_LOOKUP, 8'h00, 32'h0,         5'd0);
    send_request(REQ_LOOKUP, 8'hff, 32'hffff_ffff, 5'd31);
    send_request(REQ_ADD,    8'h00, 32'h0,         5'd31);
    send_request(REQ_ADD,    8'hff, 32'hffff_ffff, 5'd0);
    pause(3);
    send_request(REQ_ADD,    8'ha5, 32'h5a5a_a5a5, 5'd0);
    send_request(REQ_LOOKUP, 8'h00, 32'h0,         5'd1);
    send_request(REQ_LOOKUP, 8'h00, 32'h0,         5'd2);
    send_request(REQ_LOOKUP, 8'h00, 32'h0,         5'd3);
    send_request(REQ_PEEK,   8'h00, 32'h0,         5'd0);
    send_request(REQ_DELETE, 8'h00, 32'h0,         5'd0);
    send_request(REQ_LOOKUP, 8'h00, 32'h0,         5'd0);
    send_request(REQ_ADD,    8'h3c, 32'h8000_0001, 5'd0);
    send_request(REQ_PEEK,   8'h00, 32'h0,         5'd0);
    send_request(REQ_DELETE, 8'h00, 32'h0,         5'd0);
    send_request(REQ_DELETE, 8'h00, 32'h0,         5'd0);
    send_request(REQ_DELETE, 8'h00, 32'h0,         5'd0);
    send_request(REQ_DELETE, 8'h00, 32'h0,         5'd0);
    send_request(REQ_PEEK,   8'h00, 32'h0,         5'd0);

    sent     = 0;
    mix      = MIX_FILL;
    seg_left = 70;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < RANDOM_REQUESTS; i++) begin
        if (seg_left == 0) begin
          mix      = req_mix_t'($urandom_range(2));
          seg_left = $urandom_range(20, 70);
        end
        send_request(pick_request(mix), 8'($urandom), $urandom, 5'($urandom));
        seg_left--;
        sent++;
      end
      if ($urandom_range(3) != 0) pause($urandom_range(1, 8));
    end
    start = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
